// File: rtl/fxalu_pkg.sv
// ----------------------------------------------------------------------------
// fxalu_pkg
// Shared types, constants and operation codes for the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fxalu_pkg;

  localparam int DATA_W       = 32;
  localparam int FRAC_BITS_DEF = 8;

  typedef enum logic [2:0] {
    OP_ADD      = 3'd0,
    OP_SUB      = 3'd1,
    OP_MUL      = 3'd2,
    OP_DIV      = 3'd3,
    OP_MIN      = 3'd4,
    OP_MAX      = 3'd5,
    OP_TO_INT   = 3'd6,
    OP_FROM_INT = 3'd7
  } op_t;

  // Comparison flags that ride along with each item through the pipeline.
  typedef struct packed {
    logic is_equal;
    logic is_less;
    logic is_greater;
  } cmp_t;

endpackage

// File: rtl/fxalu_div.sv
// ----------------------------------------------------------------------------
// fxalu_div
// Pipelined unsigned restoring divider, one quotient bit per stage, with
// a side channel that carries an opaque tag alongside each operand pair.
// ----------------------------------------------------------------------------
module fxalu_div
  import fxalu_pkg::*;
#(
  parameter int NUM_W = 64,
  parameter int DEN_W = 33,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] in_tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quot,
  output logic [TAG_W-1:0] out_tag
);

  logic [NUM_W-1:0] q_r   [NUM_W+1];
  logic [DEN_W:0]   rem_r [NUM_W+1];
  logic [DEN_W-1:0] den_r [NUM_W+1];
  logic [TAG_W-1:0] tag_r [NUM_W+1];
  logic             vld_r [NUM_W+1];

  always_comb begin
    q_r[0]   = num;
    rem_r[0] = '0;
    den_r[0] = den;
    tag_r[0] = in_tag;
    vld_r[0] = in_valid;
  end

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic [DEN_W:0]   shifted;
    logic [DEN_W+1:0] diff;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [TAG_W-1:0] tag_reg;
    logic             vld_reg;

    always_comb begin
      shifted = {rem_r[i][DEN_W-1:0], q_r[i][NUM_W-1]};
      diff    = {1'b0, shifted} - {2'b00, den_r[i]};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_reg <= 1'b0;
      end else if (en) begin
        vld_reg <= vld_r[i];
      end
      if (en) begin
        if (!diff[DEN_W+1]) begin
          rem_reg <= diff[DEN_W:0];
          q_reg   <= {q_r[i][NUM_W-2:0], 1'b1};
        end else begin
          rem_reg <= shifted;
          q_reg   <= {q_r[i][NUM_W-2:0], 1'b0};
        end
        den_reg <= den_r[i];
        tag_reg <= tag_r[i];
      end
    end

    always_comb begin
      q_r[i+1]   = q_reg;
      rem_r[i+1] = rem_reg;
      den_r[i+1] = den_reg;
      tag_r[i+1] = tag_reg;
      vld_r[i+1] = vld_reg;
    end
  end

  assign out_valid = vld_r[NUM_W];
  assign quot      = q_r[NUM_W];
  assign out_tag   = tag_r[NUM_W];

endmodule

// File: rtl/fixed_point_alu_q24_8_top.sv
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8_top
// Signed fixed-point ALU with saturation and comparison flags.
// ----------------------------------------------------------------------------
// Every operation runs through one pipeline of fixed length, so results come
// out in order, one per cycle while the output is taken; that length is set
// by the bit-serial pipelined divider, whose 2*FRAC_BITS+32 stages every
// operation passes through. A new item is accepted in every cycle while the
// output is taken; a stall on the output halts the whole pipeline without
// loss.
module fixed_point_alu_q24_8_top
  import fxalu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,  // cmd[2:0], operand_a[34:3], operand_b[66:35], zeros
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata   // result_value[31:0], is_equal, is_less, is_greater,
                                // overflow_flag, divide_by_zero, zeros
);

  localparam int NUM_W = DATA_W + 2 * FRAC_BITS;
  localparam int MAG_W = DATA_W + 1;
  localparam int TAG_W = 3 + 3 + 2 * DATA_W;
  localparam int DEN_W_C = MAG_W + 1;

  // The whole pipeline advances only when the output slot is free.
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // ---------------- Stage 1: decode, magnitudes, sign -----------------------
  logic [2:0]              cmd_in;
  logic signed [DATA_W-1:0] a_in, b_in;
  assign cmd_in = s_tdata[2:0];
  assign a_in   = s_tdata[34:3];
  assign b_in   = s_tdata[66:35];

  logic              v1;
  op_t               op1;
  logic signed [DATA_W-1:0] a1, b1;
  logic [MAG_W-1:0]  ma1, mb1;
  logic              neg1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
    end
    if (en) begin
      op1  <= op_t'(cmd_in);
      a1   <= a_in;
      b1   <= b_in;
      ma1  <= a_in[DATA_W-1] ? MAG_W'(-{a_in[DATA_W-1], a_in}) : MAG_W'({1'b0, a_in});
      mb1  <= b_in[DATA_W-1] ? MAG_W'(-{b_in[DATA_W-1], b_in}) : MAG_W'({1'b0, b_in});
      neg1 <= a_in[DATA_W-1] ^ b_in[DATA_W-1];
    end
  end

  // ---------------- Stage 2: arithmetic core --------------------------------
  logic              v2;
  op_t               op2;
  logic signed [DATA_W-1:0] a2, b2;
  logic [2*MAG_W-1:0] prod2;
  logic signed [DATA_W:0] sum2;
  logic [MAG_W-1:0]  mb2;
  logic [MAG_W-1:0]  ma2;
  logic              neg2;
  cmp_t              cmp2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
    if (en) begin
      op2  <= op1;
      a2   <= a1;
      b2   <= b1;
      prod2 <= ma1 * mb1;
      sum2 <= (op1 == OP_SUB) ? ({a1[DATA_W-1], a1} - {b1[DATA_W-1], b1})
                              : ({a1[DATA_W-1], a1} + {b1[DATA_W-1], b1});
      ma2  <= ma1;
      mb2  <= mb1;
      neg2 <= neg1;
      cmp2.is_equal   <= (a1 == b1);
      cmp2.is_less    <= (a1 < b1);
      cmp2.is_greater <= (a1 > b1);
    end
  end

  // ---------------- Stage 3: non-divide results, divider operands -----------
  // The result of every operation but divide is formed here, saturated where
  // needed, and carried through the divider as tag.
  logic [2*MAG_W:0]  mul_q;
  logic              res_neg3;
  logic [2*MAG_W:0]  res_mag3;
  logic [DATA_W-1:0] res_direct3;
  logic              direct3;
  logic [NUM_W-1:0]  div_num3;
  logic [DEN_W_C-1:0] div_den3;

  always_comb begin
    mul_q       = ({1'b0, prod2} + (2*MAG_W+1)'(1) * (2*MAG_W+1)'(2 ** (FRAC_BITS - 1)))
                  >> FRAC_BITS;
    res_neg3    = 1'b0;
    res_mag3    = '0;
    res_direct3 = '0;
    direct3     = 1'b1;
    case (op2)
      OP_ADD, OP_SUB: begin
        direct3  = 1'b0;
        res_neg3 = sum2[DATA_W];
        res_mag3 = sum2[DATA_W] ? (2*MAG_W+1)'(-sum2) : (2*MAG_W+1)'(sum2);
      end
      OP_MUL: begin
        direct3  = 1'b0;
        res_neg3 = neg2;
        res_mag3 = mul_q;
      end
      OP_MIN:    res_direct3 = (a2 <= b2) ? a2 : b2;
      OP_MAX:    res_direct3 = (a2 >= b2) ? a2 : b2;
      OP_TO_INT: res_direct3 = DATA_W'(a2 >>> FRAC_BITS);
      OP_FROM_INT: begin
        direct3  = 1'b0;
        res_neg3 = a2[DATA_W-1];
        res_mag3 = (2*MAG_W+1)'(ma2) << FRAC_BITS;
      end
      default: direct3 = 1'b1;
    endcase
    // Rounded quotient: (2n + d) / (2d), numerator n = |a| << FRAC_BITS.
    div_num3 = (NUM_W'(ma2) << (FRAC_BITS + 1)) + NUM_W'(mb2);
    div_den3 = {mb2, 1'b0};
  end

  // Saturate a sign/magnitude pair to a signed word.
  logic [DATA_W-1:0] sat3;
  logic              ovf3;
  always_comb begin
    ovf3 = 1'b0;
    if (res_neg3) begin
      if (res_mag3 > (2*MAG_W+1)'({1'b1, {(DATA_W-1){1'b0}}})) begin
        ovf3 = 1'b1;
        sat3 = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        sat3 = DATA_W'(-res_mag3);
      end
    end else if (res_mag3 > (2*MAG_W+1)'({1'b0, {(DATA_W-1){1'b1}}})) begin
      ovf3 = 1'b1;
      sat3 = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      sat3 = res_mag3[DATA_W-1:0];
    end
  end

  logic              v3;
  logic [NUM_W-1:0]  num3_r;
  logic [DEN_W_C-1:0] den3_r;
  logic [TAG_W-1:0]  tag3_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
    if (en) begin
      num3_r <= div_num3;
      den3_r <= (mb2 == '0) ? DEN_W_C'(1) : div_den3;
      tag3_r <= {op2 == OP_DIV, mb2 == '0, neg2, cmp2,
                 direct3 ? res_direct3 : sat3, {(DATA_W-1){1'b0}}, ovf3 & !direct3};
    end
  end

  // ---------------- Divider stages ------------------------------------------
  logic              vd;
  logic [NUM_W-1:0]  qd;
  logic [TAG_W-1:0]  tagd;

  fxalu_div #(
    .NUM_W (NUM_W),
    .DEN_W (DEN_W_C),
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v3),
    .num       (num3_r),
    .den       (den3_r),
    .in_tag    (tag3_r),
    .out_valid (vd),
    .quot      (qd),
    .out_tag   (tagd)
  );

  // ---------------- Final stage: select and saturate divide -----------------
  logic              is_div, dz, dneg, oth_ovf;
  cmp_t              cmpd;
  logic [DATA_W-1:0] oth_res;
  logic [DATA_W-1:0] dres;
  logic              dovf;

  assign is_div  = tagd[TAG_W-1];
  assign dz      = tagd[TAG_W-2];
  assign dneg    = tagd[TAG_W-3];
  assign cmpd    = tagd[TAG_W-4 -: 3];
  assign oth_res = tagd[2*DATA_W-1 -: DATA_W];
  assign oth_ovf = tagd[0];

  always_comb begin
    dovf = 1'b0;
    if (dneg) begin
      if (qd > NUM_W'({1'b1, {(DATA_W-1){1'b0}}})) begin
        dovf = 1'b1;
        dres = {1'b1, {(DATA_W-1){1'b0}}};
      end else begin
        dres = DATA_W'(-qd);
      end
    end else if (qd > NUM_W'({1'b0, {(DATA_W-1){1'b1}}})) begin
      dovf = 1'b1;
      dres = {1'b0, {(DATA_W-1){1'b1}}};
    end else begin
      dres = qd[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vd;
    end
    if (en) begin
      if (is_div) begin
        m_tdata <= {3'b000, dz, dz ? 1'b0 : dovf, cmpd.is_greater, cmpd.is_less,
                    cmpd.is_equal, dz ? {DATA_W{1'b0}} : dres};
      end else begin
        m_tdata <= {3'b000, 1'b0, oth_ovf, cmpd.is_greater, cmpd.is_less,
                    cmpd.is_equal, oth_res};
      end
    end
  end

endmodule

// File: dv/fxalu_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fxalu_checker
// Watches both stream channels of the fixed-point ALU, predicts each result
// from the accepted operation and compares it field by field in order.
// ----------------------------------------------------------------------------
module fxalu_checker
  import fxalu_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [71:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,
  output int          error_count,
  output int          pending_count
);

  localparam int FB = FRAC_BITS_DEF;

  typedef struct packed {
    logic [31:0] value;
    logic        is_equal;
    logic        is_less;
    logic        is_greater;
    logic        overflow;
    logic        div_zero;
  } alu_result_t;

  alu_result_t expected_results[$];

  // Saturates a sign and magnitude into the signed 32-bit range.
  function automatic logic [31:0] saturate(input logic neg, input logic [63:0] mag,
                                           inout logic ovf);
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        ovf = 1'b1;
        return 32'h8000_0000;
      end
      return 32'(-mag);
    end
    if (mag > 64'h7FFF_FFFF) begin
      ovf = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  function automatic alu_result_t compute_alu(input op_t op, input logic signed [31:0] a,
                                              input logic signed [31:0] b);
    alu_result_t r;
    logic signed [63:0] wa, wb, s;
    logic [63:0] ma, mb, p, n;
    logic ovf;
    wa = a;
    wb = b;
    ma = (wa < 0) ? -wa : wa;
    mb = (wb < 0) ? -wb : wb;
    ovf = 1'b0;
    r = '0;
    case (op)
      OP_ADD: begin
        s = wa + wb;
        r.value = saturate(s < 0, (s < 0) ? -s : s, ovf);
      end
      OP_SUB: begin
        s = wa - wb;
        r.value = saturate(s < 0, (s < 0) ? -s : s, ovf);
      end
      OP_MUL: begin
        p = ma * mb;
        r.value = saturate((a < 0) != (b < 0), (p + (64'd1 << (FB - 1))) >> FB, ovf);
      end
      OP_DIV: begin
        if (b == 0) r.div_zero = 1'b1;
        else begin
          n = ma << FB;
          r.value = saturate((a < 0) != (b < 0), (2 * n + mb) / (2 * mb), ovf);
        end
      end
      OP_MIN: r.value = (a <= b) ? a : b;
      OP_MAX: r.value = (a >= b) ? a : b;
      OP_TO_INT: r.value = a >>> FB;
      default: r.value = saturate(a < 0, ma << FB, ovf);
    endcase
    r.overflow = ovf;
    r.is_equal = (a == b);
    r.is_less = (a < b);
    r.is_greater = (a > b);
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("checker: mismatch in %s: got %h, expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  initial error_count = 0;
  initial pending_count = 0;

  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst) begin
      if (s_tvalid && s_tready)
        expected_results.push_back(compute_alu(op_t'(s_tdata[2:0]), s_tdata[34:3],
                                               s_tdata[66:35]));
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[32], m_tdata[33], m_tdata[34], m_tdata[35],
               m_tdata[36]};
        if (expected_results.size() == 0)
          report_mismatch("unexpected transfer", got.value, '0);
        else begin
          want = expected_results.pop_front();
          if (got.value !== want.value) report_mismatch("result_value", got.value, want.value);
          if (got.is_equal !== want.is_equal)
            report_mismatch("is_equal", 32'(got.is_equal), 32'(want.is_equal));
          if (got.is_less !== want.is_less)
            report_mismatch("is_less", 32'(got.is_less), 32'(want.is_less));
          if (got.is_greater !== want.is_greater)
            report_mismatch("is_greater", 32'(got.is_greater), 32'(want.is_greater));
          if (got.overflow !== want.overflow)
            report_mismatch("overflow_flag", 32'(got.overflow), 32'(want.overflow));
          if (got.div_zero !== want.div_zero)
            report_mismatch("divide_by_zero", 32'(got.div_zero), 32'(want.div_zero));
        end
      end
    end
    pending_count = expected_results.size();
  end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives directed and random operations into the fixed-point ALU under
// several idle and stall patterns; the checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
  import fxalu_pkg::*;

  localparam int LATENCY = 2 * FRAC_BITS_DEF + 37;
  localparam int CYCLE_LIMIT = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [71:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  int          error_count;
  int          pending_count;
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  bit          hold_off = 1'b0;
  int          cycle_count = 0;

  always #5 clk = ~clk;

  fixed_point_alu_q24_8_top i_dut (.*);

  fxalu_checker i_checker (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // The receiver is random per cycle except during a long hold-off.
  always @(posedge clk)
    m_tready <= !rst && !hold_off && ($urandom_range(99) >= stall_pct);

  function automatic logic [31:0] pick_operand();
    case ($urandom_range(7))
      0: return 32'h8000_0000 + $urandom_range(3);
      1: return 32'h7FFF_FFFF - $urandom_range(3);
      2: return 32'($signed($urandom_range(2048)) - 1024);
      3: return 32'($signed($urandom_range(1 << 17)) - (1 << 16));
      4: return 32'($signed($urandom_range(1 << 24)) - (1 << 23));
      default: return $urandom;
    endcase
  endfunction

  // Offers one item and holds it until the transfer, with random idle first.
  task automatic send_op(input op_t op, input logic [31:0] a, input logic [31:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {5'b0, b, a, op};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  initial begin
    logic [31:0] a, b;
    logic [31:0] edges[6];
    edges = '{32'h8000_0000, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'h100, 32'h7FFF_FFFF};
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int k = 0; k < 8; k++) begin
      send_op(op_t'(k), edges[k % 6], edges[(k + 1) % 6]);
      send_op(op_t'(k), edges[(k + 3) % 6], edges[(k + 3) % 6]);
    end
    send_op(OP_DIV, 32'h0000_0500, 32'h0);
    send_op(OP_DIV, 32'h0000_0180, 32'h0000_0200);
    send_op(OP_MUL, 32'hFFFF_FF80, 32'h0000_0100);
    send_op(OP_MUL, 32'h0000_0080, 32'h0000_0001);
    send_op(OP_TO_INT, 32'hFFFF_FF01, 32'h0);
    send_op(OP_FROM_INT, 32'h0080_0000, 32'h1);
    send_op(OP_FROM_INT, 32'hFF80_0000, 32'h1);
    drain();

    // The sender keeps offering while the receiver holds off, so the
    // pipeline fills and stalls its input.
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 100; i++) send_op(op_t'($urandom_range(7)), pick_operand(),
                                             pick_operand());
    join
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      send_idle_pct = (phase == 1 || phase == 3) ? ((phase == 1) ? 59 : 11) : 0;
      stall_pct = (phase == 2) ? 59 : ((phase == 3) ? 11 : 0);
      for (int i = 0; i < 420; i++) begin
        a = pick_operand();
        b = ($urandom_range(9) == 0) ? a : pick_operand();
        if ($urandom_range(15) == 0) b = 32'h0;
        send_op(op_t'($urandom_range(7)), a, b);
      end
      drain();
    end

    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && pending_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/fxalu_pkg.sv
rtl/fxalu_div.sv
rtl/fixed_point_alu_q24_8_top.sv
dv/fxalu_checker.sv
dv/testbench.sv
